### sv/pfu_pkg.sv
package pfu_pkg;

    localparam int COMP_W  = 6;
    localparam int ENTRY_W = 3 * COMP_W;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_READ     = 3'd1,
        OP_SAVE     = 3'd2,
        OP_RESTORE  = 3'd3,
        OP_FADE_OUT = 3'd4,
        OP_FADE_IN  = 3'd5,
        OP_BLANK    = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        SW_SAVE,
        SW_RESTORE,
        SW_FADE_OUT,
        SW_FADE_IN,
        SW_BLANK,
        SW_CLEAR
    } sweep_t;

    typedef enum logic [1:0] {
        JMP_GOTO,
        JMP_LOOP,
        JMP_DISPATCH,
        JMP_OUT
    } jump_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UC_CLEAR_LOOP  = 3'd0;
    localparam upc_t UC_CLEAR_DRAIN = 3'd1;
    localparam upc_t UC_IDLE        = 3'd2;
    localparam upc_t UC_WRITE       = 3'd3;
    localparam upc_t UC_READ        = 3'd4;
    localparam upc_t UC_SWEEP_LOOP  = 3'd5;
    localparam upc_t UC_SWEEP_DRAIN = 3'd6;
    localparam upc_t UC_RESULT      = 3'd7;

    typedef struct packed {
        logic  accept;
        logic  sweep_rd;
        logic  wr_single;
        logic  rd_single;
        logic  out_load;
        jump_t jump;
        upc_t  target;
    } uword_t;

    function automatic uword_t ucode(upc_t pc);
        uword_t w;
        w = '0;
        unique case (pc)
            UC_CLEAR_LOOP: begin
                w.sweep_rd = 1'b1;
                w.jump     = JMP_LOOP;
                w.target   = UC_CLEAR_DRAIN;
            end
            UC_CLEAR_DRAIN: begin
                w.jump   = JMP_GOTO;
                w.target = UC_IDLE;
            end
            UC_IDLE: begin
                w.accept = 1'b1;
                w.jump   = JMP_DISPATCH;
                w.target = UC_IDLE;
            end
            UC_WRITE: begin
                w.wr_single = 1'b1;
                w.jump      = JMP_GOTO;
                w.target    = UC_RESULT;
            end
            UC_READ: begin
                w.rd_single = 1'b1;
                w.jump      = JMP_GOTO;
                w.target    = UC_RESULT;
            end
            UC_SWEEP_LOOP: begin
                w.sweep_rd = 1'b1;
                w.jump     = JMP_LOOP;
                w.target   = UC_SWEEP_DRAIN;
            end
            UC_SWEEP_DRAIN: begin
                w.jump   = JMP_GOTO;
                w.target = UC_RESULT;
            end
            UC_RESULT: begin
                w.out_load = 1'b1;
                w.jump     = JMP_OUT;
                w.target   = UC_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic upc_t entry_of(op_t op);
        upc_t pc;
        unique case (op)
            OP_WRITE:    pc = UC_WRITE;
            OP_READ:     pc = UC_READ;
            OP_SAVE,
            OP_RESTORE,
            OP_FADE_OUT,
            OP_FADE_IN,
            OP_BLANK:    pc = UC_SWEEP_LOOP;
            default:     pc = UC_RESULT;
        endcase
        return pc;
    endfunction

    function automatic sweep_t sweep_of(op_t op);
        sweep_t s;
        unique case (op)
            OP_SAVE:     s = SW_SAVE;
            OP_RESTORE:  s = SW_RESTORE;
            OP_FADE_OUT: s = SW_FADE_OUT;
            OP_FADE_IN:  s = SW_FADE_IN;
            default:     s = SW_BLANK;
        endcase
        return s;
    endfunction

    function automatic entry_t fade_out(entry_t e);
        entry_t             r;
        logic [COMP_W-1:0]  v;
        for (int i = 0; i < 3; i++) begin
            v = e[i*COMP_W +: COMP_W];
            r[i*COMP_W +: COMP_W] = (v == '0) ? v : v - 1'b1;
        end
        return r;
    endfunction

    function automatic entry_t fade_in(entry_t e, entry_t t, logic [7:0] cmax);
        entry_t             r;
        logic [COMP_W-1:0]  v;
        logic [COMP_W-1:0]  g;
        for (int i = 0; i < 3; i++) begin
            v = e[i*COMP_W +: COMP_W];
            g = t[i*COMP_W +: COMP_W];
            r[i*COMP_W +: COMP_W] = (v < g && 8'(v) < cmax) ? v + 1'b1 : v;
        end
        return r;
    endfunction

endpackage

### sv/palette_fade_unit.sv
// channel  dir  handshake          payload
// s_       in   tvalid / tready    tuser: op; tdata: index, wr_red, wr_green, wr_blue
// m_       out  tvalid / tready    tdata: rd_red, rd_green, rd_blue
//
// Write and read pass through their own step and then the result step before the next accept.
// Save, restore, blank and fade steps sweep the whole palette: the sweep reads
// one entry per cycle through the single read port of each palette RAM.
// After reset a clearing pass zeroes both RAMs; s_tready stays low meanwhile.
// Results sit in an output register; a stalled m_ side holds the sequencer only
// in its result step, and the input is taken again once the result is parked.
module palette_fade_unit
    import pfu_pkg::*;
#(
    parameter int ENTRIES       = 256,
    parameter int COMPONENT_MAX = 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // index[7:0], wr_red[13:8], wr_green[19:14], wr_blue[25:20]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // rd_red[5:0], rd_green[11:6], rd_blue[17:12]
);

    localparam int              AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0]   LAST_ADDR = AW'(ENTRIES - 1);
    localparam logic [7:0]      CMAX      = 8'(COMPONENT_MAX);
    localparam logic [10:0]     ENT_LIM   = 11'(ENTRIES);

    entry_t          live_mem [ENTRIES];
    entry_t          tgt_mem  [ENTRIES];

    uword_t          uw;
    upc_t            upc_reg, upc_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            p_vld_reg, p_vld_next;
    logic [AW-1:0]   p_addr_reg, p_addr_next;
    sweep_t          mode_reg, mode_next;
    op_t             op_reg, op_next;
    logic [7:0]      index_reg, index_next;
    entry_t          wr_data_reg, wr_data_next;
    logic            in_range_reg, in_range_next;
    logic            m_vld_reg, m_vld_next;
    entry_t          m_data_reg, m_data_next;
    entry_t          live_q_reg;
    entry_t          tgt_q_reg;

    logic            s_accept;
    logic            out_free;
    logic            cnt_last;
    logic            live_we, tgt_we, live_re;
    logic [AW-1:0]   live_waddr, live_raddr;
    entry_t          live_wdata, tgt_wdata;

    assign uw       = ucode(upc_reg);
    assign s_tready = uw.accept;
    assign s_accept = uw.accept && s_tvalid;
    assign out_free = !m_vld_reg || m_tready;
    assign cnt_last = (cnt_reg == LAST_ADDR);
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    always_comb begin
        unique case (uw.jump)
            JMP_GOTO:     upc_next = uw.target;
            JMP_LOOP:     upc_next = cnt_last ? uw.target : upc_reg;
            JMP_DISPATCH: upc_next = s_tvalid ? entry_of(op_t'(s_tuser)) : upc_reg;
            JMP_OUT:      upc_next = out_free ? uw.target : upc_reg;
        endcase
    end

    always_comb begin
        cnt_next      = cnt_reg;
        mode_next     = mode_reg;
        op_next       = op_reg;
        index_next    = index_reg;
        wr_data_next  = wr_data_reg;
        in_range_next = in_range_reg;
        if (uw.accept) begin
            cnt_next = '0;
        end else if (uw.sweep_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (s_accept) begin
            op_next       = op_t'(s_tuser);
            mode_next     = sweep_of(op_t'(s_tuser));
            index_next    = s_tdata[7:0];
            wr_data_next  = {s_tdata[25:20], s_tdata[19:14], s_tdata[13:8]};
            in_range_next = (11'(s_tdata[7:0]) < ENT_LIM);
        end
        p_vld_next  = uw.sweep_rd;
        p_addr_next = cnt_reg;
    end

    always_comb begin
        m_vld_next  = m_vld_reg;
        m_data_next = m_data_reg;
        if (uw.out_load && out_free) begin
            m_vld_next  = 1'b1;
            m_data_next = (op_reg == OP_READ && in_range_reg) ? live_q_reg : '0;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    always_comb begin
        live_re    = uw.sweep_rd || uw.rd_single;
        live_raddr = uw.sweep_rd ? cnt_reg : AW'(index_reg);
        live_we    = (uw.wr_single && in_range_reg) || (p_vld_reg && mode_reg != SW_SAVE);
        live_waddr = p_vld_reg ? p_addr_reg : AW'(index_reg);
        tgt_we     = p_vld_reg && (mode_reg == SW_SAVE || mode_reg == SW_CLEAR);
        tgt_wdata  = (mode_reg == SW_SAVE) ? live_q_reg : '0;
        if (!p_vld_reg) begin
            live_wdata = wr_data_reg;
        end else begin
            unique case (mode_reg)
                SW_RESTORE:  live_wdata = tgt_q_reg;
                SW_FADE_OUT: live_wdata = fade_out(live_q_reg);
                SW_FADE_IN:  live_wdata = fade_in(live_q_reg, tgt_q_reg, CMAX);
                default:     live_wdata = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (live_we) begin
            live_mem[live_waddr] <= live_wdata;
        end
        if (live_re) begin
            live_q_reg <= live_mem[live_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (tgt_we) begin
            tgt_mem[p_addr_reg] <= tgt_wdata;
        end
        if (uw.sweep_rd) begin
            tgt_q_reg <= tgt_mem[cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg   <= UC_CLEAR_LOOP;
            cnt_reg   <= '0;
            p_vld_reg <= 1'b0;
            mode_reg  <= SW_CLEAR;
            m_vld_reg <= 1'b0;
        end else begin
            upc_reg   <= upc_next;
            cnt_reg   <= cnt_next;
            p_vld_reg <= p_vld_next;
            mode_reg  <= mode_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_addr_reg   <= p_addr_next;
        op_reg       <= op_next;
        index_reg    <= index_next;
        wr_data_reg  <= wr_data_next;
        in_range_reg <= in_range_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    a_no_accept_mid_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !p_vld_reg)
        else $error("input taken while a sweep write is pending");

    a_clear_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == UC_CLEAR_LOOP || upc_reg == UC_CLEAR_DRAIN)
            |-> (mode_reg == SW_CLEAR && !m_vld_reg))
        else $error("clearing pass out of order");

    a_sweep_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.sweep_rd && p_vld_reg) |-> (cnt_reg == AW'(p_addr_reg + 1'b1)))
        else $error("sweep address skipped");

    a_result_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.out_load && out_free) |=> (upc_reg == UC_IDLE && m_vld_reg))
        else $error("result not parked before idle");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pfu_pkg::*;

    localparam int          PAL_ENTRIES = 256;
    localparam int          COMP_CEIL   = 63;
    localparam logic [2:0]  OP_UNUSED   = 3'd7;

    // red in [0], green in [1], blue in [2]; same layout as m_tdata[17:0]
    typedef logic [2:0][5:0] rgb_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // index[7:0], wr_red[13:8], wr_green[19:14], wr_blue[25:20]
    logic [2:0]  s_tuser;   // op[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // rd_red[5:0], rd_green[11:6], rd_blue[17:12]

    rgb_t        live_pal   [PAL_ENTRIES];
    rgb_t        target_pal [PAL_ENTRIES];
    rgb_t        rd_expected [$];
    logic [7:0]  hot_idx [$];
    string       comp_name [3] = '{"rd_red", "rd_green", "rd_blue"};

    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          errors       = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          ops_sent [8];

    palette_fade_unit #(
        .ENTRIES       (PAL_ENTRIES),
        .COMPONENT_MAX (COMP_CEIL)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Palette predictor: applies one operation, returns the read data
    task automatic predict_palette_op(input logic [2:0] op, input logic [7:0] idx,
                                      input rgb_t wr, output rgb_t rd);
        rd = '0;
        case (op)
            OP_WRITE: begin
                if (int'(idx) < PAL_ENTRIES) live_pal[idx] = wr;
            end
            OP_READ: begin
                if (int'(idx) < PAL_ENTRIES) rd = live_pal[idx];
            end
            OP_SAVE: begin
                for (int e = 0; e < PAL_ENTRIES; e++) target_pal[e] = live_pal[e];
            end
            OP_RESTORE: begin
                for (int e = 0; e < PAL_ENTRIES; e++) live_pal[e] = target_pal[e];
            end
            OP_FADE_OUT: begin
                for (int e = 0; e < PAL_ENTRIES; e++)
                    for (int c = 0; c < 3; c++)
                        if (live_pal[e][c] != 6'd0) live_pal[e][c] = live_pal[e][c] - 6'd1;
            end
            OP_FADE_IN: begin
                for (int e = 0; e < PAL_ENTRIES; e++)
                    for (int c = 0; c < 3; c++)
                        if (live_pal[e][c] < target_pal[e][c] && int'(live_pal[e][c]) < COMP_CEIL)
                            live_pal[e][c] = live_pal[e][c] + 6'd1;
            end
            OP_BLANK: begin
                for (int e = 0; e < PAL_ENTRIES; e++) live_pal[e] = '0;
            end
            default: ;
        endcase
    endtask

    // Called at a falling edge; returns at a falling edge with s_tvalid low
    task automatic send_op(input logic [2:0] op, input logic [7:0] idx,
                           input logic [5:0] r, input logic [5:0] g, input logic [5:0] b);
        rgb_t rd;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {6'd0, b, g, r, idx};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_palette_op(op, idx, {b, g, r}, rd);
        rd_expected.push_back(rd);
        ops_sent[op]++;
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [5:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return 6'd0;
            1:       return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    // Operation with don't-care fields still randomized
    task automatic send_plain(input logic [2:0] op);
        send_op(op, 8'($urandom_range(0, 255)), rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic write_random();
        logic [7:0] idx;
        idx = 8'($urandom_range(0, 255));
        hot_idx.push_back(idx);
        if (hot_idx.size() > 32) void'(hot_idx.pop_front());
        send_op(OP_WRITE, idx, rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic read_hot();
        logic [7:0] idx;
        if (hot_idx.size() != 0 && $urandom_range(0, 3) != 0)
            idx = hot_idx[$urandom_range(0, hot_idx.size() - 1)];
        else
            idx = 8'($urandom_range(0, 255));
        send_op(OP_READ, idx, rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic wait_drained();
        while (rd_expected.size() != 0) @(negedge aclk);
    endtask

    // Typical fade sequence with random content, plus some noise
    task automatic run_scene();
        int k;
        repeat ($urandom_range(1, 5)) write_random();
        if ($urandom_range(0, 4) != 0) send_plain(OP_SAVE);
        case ($urandom_range(0, 2))
            0: begin
                k = $urandom_range(1, 6);
                repeat (k) begin
                    send_plain(OP_FADE_OUT);
                    if ($urandom_range(0, 1) == 0) read_hot();
                end
            end
            1: begin
                send_plain(OP_BLANK);
                read_hot();
            end
            default: read_hot();
        endcase
        k = $urandom_range(1, 8);
        repeat (k) begin
            send_plain(OP_FADE_IN);
            if ($urandom_range(0, 1) == 0) read_hot();
        end
        if ($urandom_range(0, 1) == 0) begin
            send_plain(OP_RESTORE);
            read_hot();
        end
        repeat ($urandom_range(0, 2)) send_plain(3'($urandom_range(0, 7)));
    endtask

    task automatic test_reset_state();
        send_op(OP_READ, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'd255, 6'd63, 6'd63, 6'd63);
        send_op(OP_FADE_IN, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_FADE_OUT, 8'd255, 6'd63, 6'd63, 6'd63);
    endtask

    task automatic test_directed_cases();
        send_op(OP_WRITE, 8'd0, 6'd63, 6'd63, 6'd63);
        send_op(OP_WRITE, 8'd255, 6'd1, 6'd0, 6'd63);
        send_op(OP_WRITE, 8'hAA, 6'd42, 6'd21, 6'd42);
        send_op(OP_WRITE, 8'h55, 6'd21, 6'd42, 6'd21);
        send_op(OP_READ, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'd255, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'hAA, 6'd0, 6'd0, 6'd0);
        // unused opcode must leave the palette alone and return zero
        send_op(OP_UNUSED, 8'd0, 6'd5, 6'd5, 6'd5);
        send_op(OP_READ, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_SAVE, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_FADE_OUT, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'd255, 6'd0, 6'd0, 6'd0);
        send_op(OP_FADE_OUT, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_FADE_IN, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_BLANK, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'hAA, 6'd0, 6'd0, 6'd0);
        send_op(OP_FADE_IN, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'hAA, 6'd0, 6'd0, 6'd0);
        send_op(OP_RESTORE, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'h55, 6'd0, 6'd0, 6'd0);
        // at target and at the ceiling: no change
        send_op(OP_FADE_IN, 8'd0, 6'd0, 6'd0, 6'd0);
        send_op(OP_READ, 8'd0, 6'd0, 6'd0, 6'd0);
    endtask

    task automatic test_random_scenes();
        while (items_sent < 400) run_scene();
    endtask

    task automatic test_pause_until_drained();
        write_random();
        wait_drained();
        send_plain(OP_SAVE);
        wait_drained();
        send_plain(OP_FADE_OUT);
        wait_drained();
        read_hot();
        wait_drained();
    endtask

    task automatic test_back_to_back();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (items_sent < 450) run_scene();
    endtask

    // Result sink with random backpressure
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (sink_idle_en && aresetn && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (rd_expected.size() == 0) begin
                $error("unexpected result transaction, m_tdata=%h", m_tdata);
                errors++;
            end else begin
                want = rd_expected.pop_front();
                results_seen++;
                for (int c = 0; c < 3; c++)
                    if (m_tdata[c*6 +: 6] !== want[c]) begin
                        $error("%s expected %0d actual %0d", comp_name[c], want[c],
                               m_tdata[c*6 +: 6]);
                        errors++;
                    end
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        for (int e = 0; e < PAL_ENTRIES; e++) begin
            live_pal[e]   = '0;
            target_pal[e] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_directed_cases();
        test_random_scenes();
        test_pause_until_drained();
        test_back_to_back();

        wait_drained();
        repeat (PAL_ENTRIES + 20) @(negedge aclk);
        if (rd_expected.size() != 0) begin
            $error("%0d expected results never arrived", rd_expected.size());
            errors++;
        end
        $display("Covered %0d transactions: %0d write, %0d read, %0d save, %0d restore,",
                 items_sent, ops_sent[OP_WRITE], ops_sent[OP_READ], ops_sent[OP_SAVE],
                 ops_sent[OP_RESTORE]);
        $display("  %0d fade-out, %0d fade-in, %0d blank, %0d unused op; %0d results checked",
                 ops_sent[OP_FADE_OUT], ops_sent[OP_FADE_IN], ops_sent[OP_BLANK],
                 ops_sent[OP_UNUSED], results_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
